// ===== hdl/cgfb_pkg.sv =====
// Shared types and constants of the complex gammatone filterbank.
package cgfb_pkg;

  localparam int SampleW = 16;
  localparam int CoefW   = 24;
  localparam int StateW  = 32;

  localparam logic [3:0] OrderReset = 4'd4;
  localparam logic [4:0] BandsReset = 5'd16;
  localparam logic [1:0] ChansReset = 2'd1;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegOrder = 2'd0;
  localparam logic [1:0] RegBands = 2'd1;
  localparam logic [1:0] RegChans = 2'd2;

  // Datapath operation selected by the controller.
  localparam logic [2:0] OpIdle   = 3'd0;
  localparam logic [2:0] OpNorm   = 3'd1;
  localparam logic [2:0] OpStage  = 3'd2;
  localparam logic [2:0] OpLoad   = 3'd3;

  typedef struct packed {
    logic [2:0] op;
    logic       mult_go;
    logic       acc_go;
    logic       state_rd;
    logic       state_wr;
    logic       load_out;
  } cgfb_cmd_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [StateW-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    begin
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (v > hi) sat32 = 32'h7fffffff;
      else if (v < lo) sat32 = 32'h80000000;
      else sat32 = v[StateW-1:0];
    end
  endfunction

endpackage

// ===== hdl/cgfb_datapath.sv =====
// Datapath: coefficient stores, stage state memory and one shared complex multiply unit.
module cgfb_datapath
  import cgfb_pkg::*;
#(
  parameter int NUM_BANDS    = 16,
  parameter int NUM_CHANS    = 2,
  parameter int MAX_ORDER    = 8,
  parameter int BW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1,
  parameter int CW = (NUM_CHANS > 1) ? $clog2(NUM_CHANS) : 1,
  parameter int KW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
  input  logic                      clk,
  input  cgfb_cmd_t                 cmd,
  input  logic [CW-1:0]             ch,
  input  logic [BW-1:0]             band,
  input  logic [KW-1:0]             stage,
  input  logic signed [SampleW-1:0] smp,
  input  logic [BW-1:0]             ld_band,
  input  logic signed [CoefW-1:0]   ld_coeff_re,
  input  logic signed [CoefW-1:0]   ld_coeff_im,
  input  logic signed [CoefW-1:0]   ld_norm_re,
  input  logic signed [CoefW-1:0]   ld_norm_im,
  input  logic                      clr,
  output logic signed [StateW-1:0]  x_re,
  output logic signed [StateW-1:0]  x_im
);

  localparam int AW = CW + BW + KW;
  // The address is the concatenation {channel, band, stage}.
  localparam int Depth = 2 ** AW;

  logic [4*CoefW-1:0]  coef_mem [NUM_BANDS];
  logic [2*StateW-1:0] st_mem [Depth];
  logic [4*CoefW-1:0]  coef_q;
  logic [2*StateW-1:0] st_q;
  logic [AW-1:0]       addr;

  logic signed [CoefW-1:0] c_re, c_im, n_re, n_im;
  logic signed [StateW-1:0] s_re, s_im;
  logic signed [63:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [63:0] sum_re, sum_im;

  assign addr = {ch, band, stage};
  assign {c_re, c_im, n_re, n_im} = coef_q;
  assign {s_re, s_im} = st_q;

  // Coefficient store, one row per band.
  always_ff @(posedge clk) begin
    if (cmd.op == OpLoad) begin
      coef_mem[ld_band] <= {ld_coeff_re, ld_coeff_im, ld_norm_re, ld_norm_im};
    end
    coef_q <= coef_mem[band];
  end

  // Stage state memory, one complex word per channel, band and stage.
  // A clear pass writes zero instead of the accumulator.
  always_ff @(posedge clk) begin
    if (cmd.state_wr) begin
      st_mem[addr] <= clr ? '0 : {x_re, x_im};
    end
    if (cmd.state_rd) begin
      st_q <= st_mem[addr];
    end
  end

  // Four partial products, registered before the sums.
  always_ff @(posedge clk) begin
    if (cmd.mult_go) begin
      if (cmd.op == OpNorm) begin
        p_rr <= 64'(smp) * 64'(n_re);
        p_ii <= 64'(smp) * 64'(n_im);
        p_ri <= '0;
        p_ir <= '0;
      end else begin
        p_rr <= 64'(s_re) * 64'(c_re);
        p_ii <= 64'(s_im) * 64'(c_im);
        p_ri <= 64'(s_re) * 64'(c_im);
        p_ir <= 64'(s_im) * 64'(c_re);
      end
    end
  end

  // Rounding, and for stage operations accumulation with the stage input.
  always_comb begin
    if (cmd.op == OpNorm) begin
      sum_re = (p_rr + 64'sd4096) >>> 13;
      sum_im = (p_ii + 64'sd4096) >>> 13;
    end else begin
      sum_re = (p_rr - p_ii + (64'(x_re) <<< 22) + 64'sd2097152) >>> 22;
      sum_im = (p_ri + p_ir + (64'(x_im) <<< 22) + 64'sd2097152) >>> 22;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_go) begin
      x_re <= sat32(sum_re);
      x_im <= sat32(sum_im);
    end
  end

endmodule

// ===== hdl/cgfb_ctrl.sv =====
// Controller: sequences bands and stages of one sample, loads of one band and clear passes.
module cgfb_ctrl
  import cgfb_pkg::*;
#(
  parameter int NUM_BANDS    = 16,
  parameter int NUM_CHANS    = 2,
  parameter int MAX_ORDER    = 8,
  parameter int BW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1,
  parameter int CW = (NUM_CHANS > 1) ? $clog2(NUM_CHANS) : 1,
  parameter int KW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          start_load,
  input  logic [BW-1:0] ld_band_in,
  input  logic [4:0]    order_cnt,
  input  logic [6:0]    band_cnt,
  input  logic          clear_all,
  input  logic          out_free,
  output logic          busy,
  output cgfb_cmd_t     cmd,
  output logic [BW-1:0] band,
  output logic [KW-1:0] stage,
  output logic [CW-1:0] clr_ch,
  output logic          clr_sel,
  output logic          emit,
  output logic          emit_last
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CRD   = 4'd1;
  localparam logic [3:0] S_NMUL  = 4'd2;
  localparam logic [3:0] S_NACC  = 4'd3;
  localparam logic [3:0] S_SRD   = 4'd4;
  localparam logic [3:0] S_SMUL  = 4'd5;
  localparam logic [3:0] S_SACC  = 4'd6;
  localparam logic [3:0] S_SWR   = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;
  localparam logic [3:0] S_CLR   = 4'd9;
  localparam logic [3:0] S_CDATA = 4'd10;

  logic [3:0] state, state_next;
  logic       clr_one;
  logic [CW+KW-1:0] ccnt;
  // A full clear pass walks every address of the {channel, band, stage} space.
  localparam int BandStates = 2 ** (CW + KW);
  localparam int AW = CW + BW + KW;
  localparam int AllStates = 2 ** AW;
  logic [AW:0] acnt;
  logic [KW-1:0] stg;
  logic [BW-1:0] bnd;

  assign busy = (state != S_IDLE);
  assign clr_sel = (state == S_CLR);
  assign emit_last = (7'(band) + 7'd1 == band_cnt);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.op = OpStage;
    emit = 1'b0;
    case (state)
      S_IDLE: begin
        if (clear_all) state_next = S_CLR;
        else if (start_load) begin
          cmd.op = OpLoad;
          state_next = S_CLR;
        end else if (start) state_next = S_CRD;
      end
      S_CRD: state_next = S_CDATA;
      S_CDATA: begin
        cmd.op = OpNorm;
        cmd.mult_go = 1'b1;
        state_next = S_NACC;
      end
      S_NACC: begin
        cmd.op = OpNorm;
        cmd.acc_go = 1'b1;
        state_next = (order_cnt == 5'd0) ? S_EMIT : S_SRD;
      end
      S_SRD: begin
        cmd.state_rd = 1'b1;
        state_next = S_SMUL;
      end
      S_SMUL: begin
        cmd.mult_go = 1'b1;
        state_next = S_SACC;
      end
      S_SACC: begin
        cmd.acc_go = 1'b1;
        state_next = S_SWR;
      end
      S_SWR: begin
        cmd.state_wr = 1'b1;
        state_next = (5'(stage) + 5'd1 == order_cnt) ? S_EMIT : S_SRD;
      end
      S_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          state_next = emit_last ? S_IDLE : S_CRD;
        end
      end
      S_CLR: begin
        cmd.state_wr = 1'b1;
        if (clr_one ? (ccnt == (CW+KW)'(BandStates - 1))
                    : (acnt == (AW+1)'(AllStates - 1))) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Clear pass address: one band in all channels, or the whole memory.
  always_comb begin
    if (state == S_CLR) begin
      if (clr_one) begin
        clr_ch = ccnt[CW+KW-1:KW];
        stage  = ccnt[KW-1:0];
      end else begin
        clr_ch = acnt[AW-1:BW+KW];
        stage  = acnt[KW-1:0];
      end
    end else begin
      clr_ch = '0;
      stage  = stg;
    end
  end

  always_comb begin
    if (state == S_CLR && !clr_one) band = acnt[BW+KW-1:KW];
    else band = bnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_one <= 1'b0;
      ccnt <= '0;
      acnt <= '0;
      stg <= '0;
      bnd <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        ccnt <= '0;
        acnt <= '0;
        stg <= '0;
        bnd <= (!clear_all && start_load) ? ld_band_in : '0;
        clr_one <= !clear_all && start_load;
      end
      if (state == S_CLR) begin
        ccnt <= ccnt + 1'b1;
        acnt <= acnt + 1'b1;
      end
      if (state == S_SWR) stg <= stg + 1'b1;
      if (state == S_EMIT && out_free) begin
        stg <= '0;
        bnd <= bnd + 1'b1;
      end
    end
  end

endmodule

// ===== hdl/complex_gammatone_filterbank.sv =====
// Top level of the complex gammatone filterbank.
// Usage:
//   Input items arrive on the valid/ready channel in_*. A filter item (mode 0)
//   gives one result transfer per band in use, band 0 first, with last_band
//   set on the highest band. A load item (mode 1) writes one band's factors
//   and clears that band's stage states in all channels; it gives no result.
//   Each band runs the normalization (coefficient read, multiply, round), then
//   each filter stage (state read, multiply, accumulate, state write) through
//   the one shared complex multiplier and the state memory port, then its
//   output step. A new item is accepted only once the sequencer has finished
//   the bands of the previous sample or the clear of the previous load.
//   The output register holds a result until it is taken; while the receiver
//   stalls, the sequencer waits before the next band.
//   After reset, and after a write to the order, bands or channels register
//   made while idle, a clear pass over every {channel, band, stage} address
//   zeroes the state memory; no item is accepted meanwhile. Configuration is
//   to be written over APB only while idle; the block does not enforce this.
module complex_gammatone_filterbank
  import cgfb_pkg::*;
#(
  parameter int NUM_BANDS    = 16,
  parameter int NUM_CHANS    = 2,
  parameter int MAX_ORDER    = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      mode,
  input  logic                      channel_index,
  input  logic signed [15:0]        sample,
  input  logic [3:0]                band_index,
  input  logic signed [23:0]        coeff_re,
  input  logic signed [23:0]        coeff_im,
  input  logic signed [23:0]        norm_re,
  input  logic signed [23:0]        norm_im,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_channel,
  output logic [3:0]                out_band,
  output logic signed [31:0]        out_re,
  output logic signed [31:0]        out_im,
  output logic                      last_band
);

  localparam int BW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int CW = (NUM_CHANS > 1) ? $clog2(NUM_CHANS) : 1;
  localparam int KW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  logic [3:0] filter_order;
  logic [4:0] bands_in_use;
  logic [1:0] channels_in_use;
  logic       cfg_wr;
  logic       clear_all;

  logic [4:0] order_cnt;
  logic [6:0] band_cnt;
  logic [3:0] chan_cnt;

  logic          busy, start, start_load, in_fire, emit, emit_last, clr_sel;
  cgfb_cmd_t     cmd, dp_cmd;
  logic [BW-1:0] band, ld_band;
  logic [KW-1:0] stage;
  logic [CW-1:0] clr_ch, cur_ch, dp_ch;
  logic signed [15:0] smp;
  logic signed [31:0] x_re, x_im;
  logic out_free;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_order <= OrderReset;
      bands_in_use <= BandsReset;
      channels_in_use <= ChansReset;
      clear_all <= 1'b0;
    end else begin
      clear_all <= 1'b0;
      if (cfg_wr) begin
        case (paddr[3:2])
          RegOrder: begin
            filter_order <= pwdata[3:0];
            clear_all <= 1'b1;
          end
          RegBands: begin
            bands_in_use <= pwdata[4:0];
            clear_all <= 1'b1;
          end
          RegChans: begin
            channels_in_use <= pwdata[1:0];
            clear_all <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegOrder: prdata = {28'd0, filter_order};
      RegBands: prdata = {27'd0, bands_in_use};
      RegChans: prdata = {30'd0, channels_in_use};
      default:  prdata = '0;
    endcase
  end

  // Clamped counts.
  always_comb begin
    order_cnt = ({1'b0, filter_order} > 5'(MAX_ORDER)) ? 5'(MAX_ORDER) : {1'b0, filter_order};
    if (bands_in_use == 5'd0) band_cnt = 7'd1;
    else if ({2'b0, bands_in_use} > 7'(NUM_BANDS)) band_cnt = 7'(NUM_BANDS);
    else band_cnt = {2'b0, bands_in_use};
    if (channels_in_use == 2'd0) chan_cnt = 4'd1;
    else if ({2'b0, channels_in_use} > 4'(NUM_CHANS)) chan_cnt = 4'(NUM_CHANS);
    else chan_cnt = {2'b0, channels_in_use};
  end

  // Input transfer: out-of-range items are dropped at once.
  assign in_ready = !busy && !clear_all && !cfg_wr;
  assign in_fire  = in_valid && in_ready;
  assign start_load = in_fire && mode && ({3'b0, band_index} < 7'(NUM_BANDS));
  assign start = in_fire && !mode && ({3'b0, channel_index} < chan_cnt);
  assign ld_band = BW'(band_index);

  always_ff @(posedge clk) begin
    if (start) begin
      smp <= sample;
      cur_ch <= CW'(channel_index);
    end
  end

  assign dp_ch = clr_sel ? clr_ch : cur_ch;

  // During a clear pass the datapath writes zero to the state memory.
  always_comb begin
    dp_cmd = cmd;
  end

  logic signed [31:0] wr_re, wr_im;
  assign wr_re = x_re;
  assign wr_im = x_im;

  cgfb_ctrl #(
    .NUM_BANDS(NUM_BANDS), .NUM_CHANS(NUM_CHANS), .MAX_ORDER(MAX_ORDER)
  ) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .start_load(start_load),
    .ld_band_in(ld_band), .order_cnt(order_cnt), .band_cnt(band_cnt),
    .clear_all(clear_all), .out_free(out_free), .busy(busy), .cmd(cmd),
    .band(band), .stage(stage), .clr_ch(clr_ch), .clr_sel(clr_sel),
    .emit(emit), .emit_last(emit_last)
  );

  logic signed [31:0] dp_re, dp_im;
  cgfb_datapath #(
    .NUM_BANDS(NUM_BANDS), .NUM_CHANS(NUM_CHANS), .MAX_ORDER(MAX_ORDER)
  ) u_dp (
    .clk(clk), .cmd(dp_cmd), .ch(dp_ch), .band(band), .stage(stage), .smp(smp),
    .ld_band(ld_band), .ld_coeff_re(coeff_re), .ld_coeff_im(coeff_im),
    .ld_norm_re(norm_re), .ld_norm_im(norm_im), .clr(clr_sel),
    .x_re(dp_re), .x_im(dp_im)
  );
  assign x_re = dp_re;
  assign x_im = dp_im;

  // Output register.
  assign out_free = !out_valid || out_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_channel <= 1'(cur_ch);
      out_band    <= 4'(band);
      out_re      <= wr_re;
      out_im      <= wr_im;
      last_band   <= emit_last;
    end
  end

endmodule

// ===== dv/complex_gammatone_filterbank_tb.sv =====
// Self-checking testbench for the complex gammatone filterbank.
module complex_gammatone_filterbank_tb
  import cgfb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumBands  = 16;
  localparam int NumChans  = 2;
  localparam int MaxOrder  = 8;
  localparam int IdleLimit = 20000;
  localparam int DrainWait = 100;
  localparam int HoldLen   = 3000;
  localparam logic ModeFilter = 1'b0;
  localparam logic ModeLoad   = 1'b1;

  typedef struct {
    logic               mode;
    logic               channel_index;
    logic signed [15:0] sample;
    logic [3:0]         band_index;
    logic signed [23:0] coeff_re;
    logic signed [23:0] coeff_im;
    logic signed [23:0] norm_re;
    logic signed [23:0] norm_im;
  } filter_item_t;

  typedef struct {
    logic               channel;
    logic [3:0]         band;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               last;
  } band_result_t;

  // Predictor of the band outputs plus the queue of band results still owed.
  class gammatone_scoreboard;
    int unsigned  order_reg, bands_reg, chans_reg;
    int           coef_re[NumBands], coef_im[NumBands];
    int           nrm_re[NumBands], nrm_im[NumBands];
    int           st_re[NumChans][NumBands][MaxOrder];
    int           st_im[NumChans][NumBands][MaxOrder];
    band_result_t pending[$];
    int unsigned  errors, results_seen, samples_seen, loads_seen;

    function new();
      order_reg = OrderReset;
      bands_reg = BandsReset;
      chans_reg = ChansReset;
      errors = 0;
      results_seen = 0;
      samples_seen = 0;
      loads_seen = 0;
      clear_states();
    endfunction

    function void clear_states();
      foreach (st_re[c, b, k]) begin
        st_re[c][b][k] = 0;
        st_im[c][b][k] = 0;
      end
    endfunction

    // Round half up, floor shift, then saturate to 32 bits.
    function int round_sat(longint v, int s);
      longint r;
      r = (v + (longint'(1) << (s - 1))) >>> s;
      if (r > 64'sd2147483647) return 32'sh7fffffff;
      if (r < -64'sd2147483648) return 32'sh80000000;
      return int'(r);
    endfunction

    function void write_reg(logic [1:0] idx, int unsigned val);
      case (idx)
        RegOrder: order_reg = val & 'hf;
        RegBands: bands_reg = val & 'h1f;
        RegChans: chans_reg = val & 'h3;
        default: return;
      endcase
      clear_states();
    endfunction

    function void note_input(filter_item_t it);
      int unsigned  order, bands, chans, ch;
      int           x_re, x_im, b_i;
      longint       p_re, p_im, s_re, s_im, c_re, c_im;
      band_result_t r;
      if (it.mode == ModeLoad) begin
        b_i = it.band_index;
        coef_re[b_i] = it.coeff_re;
        coef_im[b_i] = it.coeff_im;
        nrm_re[b_i] = it.norm_re;
        nrm_im[b_i] = it.norm_im;
        for (int c = 0; c < NumChans; c++)
          for (int k = 0; k < MaxOrder; k++) begin
            st_re[c][b_i][k] = 0;
            st_im[c][b_i][k] = 0;
          end
        loads_seen++;
        return;
      end
      order = (order_reg > MaxOrder) ? MaxOrder : order_reg;
      bands = (bands_reg < 1) ? 1 : ((bands_reg > NumBands) ? NumBands : bands_reg);
      chans = (chans_reg < 1) ? 1 : ((chans_reg > NumChans) ? NumChans : chans_reg);
      ch = it.channel_index;
      // Samples on a channel that is not in use are dropped.
      if (ch >= chans) return;
      samples_seen++;
      for (int b = 0; b < bands; b++) begin
        x_re = round_sat(longint'(it.sample) * longint'(nrm_re[b]), 13);
        x_im = round_sat(longint'(it.sample) * longint'(nrm_im[b]), 13);
        c_re = coef_re[b];
        c_im = coef_im[b];
        for (int k = 0; k < order; k++) begin
          s_re = st_re[ch][b][k];
          s_im = st_im[ch][b][k];
          p_re = s_re * c_re - s_im * c_im + (longint'(x_re) <<< 22);
          p_im = s_re * c_im + s_im * c_re + (longint'(x_im) <<< 22);
          st_re[ch][b][k] = round_sat(p_re, 22);
          st_im[ch][b][k] = round_sat(p_im, 22);
          x_re = st_re[ch][b][k];
          x_im = st_im[ch][b][k];
        end
        r.channel = ch[0];
        r.band = b[3:0];
        r.re = x_re;
        r.im = x_im;
        r.last = (b + 1 == bands);
        pending.push_back(r);
      end
    endfunction

    function void check_result(band_result_t got);
      band_result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        $error("band result with nothing expected: band %0d", got.band);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.channel !== want.channel) begin
        $error("out_channel: expected %0d, got %0d", want.channel, got.channel);
        errors++;
      end
      if (got.band !== want.band) begin
        $error("out_band: expected %0d, got %0d", want.band, got.band);
        errors++;
      end
      if (got.re !== want.re) begin
        $error("out_re: expected %0d, got %0d", want.re, got.re);
        errors++;
      end
      if (got.im !== want.im) begin
        $error("out_im: expected %0d, got %0d", want.im, got.im);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_band: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               psel, penable, pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid, in_ready;
  logic               mode, channel_index;
  logic signed [15:0] sample;
  logic [3:0]         band_index;
  logic signed [23:0] coeff_re, coeff_im, norm_re, norm_im;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_channel;
  logic [3:0]         out_band;
  logic signed [31:0] out_re, out_im;
  logic               last_band;

  gammatone_scoreboard sb;
  int unsigned         send_idle_pct;
  int unsigned         recv_stall_pct;
  logic                hold_req;
  logic                hold_taken = 1'b0;
  int unsigned         hold_cycles = 0;
  int unsigned         quiet_cycles = 0;

  complex_gammatone_filterbank u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .channel_index(channel_index), .sample(sample),
    .band_index(band_index), .coeff_re(coeff_re), .coeff_im(coeff_im),
    .norm_re(norm_re), .norm_im(norm_im),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_channel(out_channel), .out_band(out_band),
    .out_re(out_re), .out_im(out_im), .last_band(last_band)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stalls, or one long counted hold-off once requested.
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cycles <= HoldLen;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output monitor: every result transfer goes to the scoreboard.
  always @(posedge clk) begin
    band_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.channel = out_channel;
      got.band = out_band;
      got.re = out_re;
      got.im = out_im;
      got.last = last_band;
      sb.check_result(got);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item after random gaps and wait for its transfer.
  task automatic send_item(filter_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= it.mode;
    channel_index <= it.channel_index;
    sample <= it.sample;
    band_index <= it.band_index;
    coeff_re <= it.coeff_re;
    coeff_im <= it.coeff_im;
    norm_re <= it.norm_re;
    norm_im <= it.norm_im;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  // Register write over the configuration port, setup phase then access phase.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Stop offering items, wait for all owed results, then let loads finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // Random item of the given mode: all fields random, coefficients mostly shaped.
  function automatic filter_item_t random_item(logic m);
    filter_item_t it;
    it.mode = m;
    it.channel_index = 1'($urandom_range(1));
    it.sample = 16'($urandom);
    if ($urandom_range(9) == 0) it.sample = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    it.band_index = 4'($urandom_range(NumBands - 1));
    it.coeff_re = 24'($urandom);
    it.coeff_im = 24'($urandom);
    it.norm_re = 24'($urandom);
    it.norm_im = 24'($urandom);
    // Mostly decaying poles so the cascade rings instead of saturating.
    if ($urandom_range(3) != 0) begin
      it.coeff_re = 24'($signed($urandom_range(7800000)) - 3900000);
      it.coeff_im = 24'($signed($urandom_range(3000000)) - 1500000);
    end
    return it;
  endfunction

  initial begin
    filter_item_t it;
    int unsigned ph_order[8] = '{0, 8, 15, 1, 2, 3, 5, 8};
    int unsigned ph_bands[8] = '{16, 4, 1, 0, 31, 8, 6, 16};
    int unsigned ph_chans[8] = '{2, 2, 3, 0, 2, 2, 1, 2};
    int unsigned ph_send[8]  = '{0, 84, 0, 15, 0, 15, 0, 84};
    int unsigned ph_recv[8]  = '{0, 0, 84, 15, 0, 15, 84, 0};
    int unsigned ph_items[8] = '{40, 50, 50, 50, 40, 60, 50, 40};

    sb = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    mode = ModeFilter;
    channel_index = 1'b0;
    sample = '0;
    band_index = '0;
    coeff_re = '0;
    coeff_im = '0;
    norm_re = '0;
    norm_im = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part: load every band, extremes on a few, edge samples, one reload.
    for (int b = 0; b < NumBands; b++) begin
      it = random_item(ModeLoad);
      it.band_index = 4'(b);
      if (b == 0) begin
        it.coeff_re = 24'sh7fffff;
        it.coeff_im = 24'sh7fffff;
        it.norm_re = 24'sh7fffff;
        it.norm_im = 24'sh800000;
      end else if (b == 1) begin
        it.coeff_re = 24'sh800000;
        it.coeff_im = 24'sh800000;
        it.norm_re = 24'sh800000;
        it.norm_im = 24'sh7fffff;
      end else if (b == 2) begin
        it.coeff_re = '0;
        it.coeff_im = '0;
      end
      send_item(it);
    end
    foreach (ph_order[i]) begin
      it = random_item(ModeFilter);
      it.channel_index = 1'b0;
      case (i)
        0: it.sample = 16'sh7fff;
        1: it.sample = 16'sh8000;
        2: it.sample = '0;
        3: it.sample = 16'sd1;
        4: it.channel_index = 1'b1;
        5: begin
          it = random_item(ModeLoad);
          it.band_index = 4'd3;
        end
        default: ;
      endcase
      if (i < 6) send_item(it);
    end

    // Random phases, each under its own register setting and idling pattern.
    foreach (ph_order[p]) begin
      drain();
      write_reg(RegOrder, ph_order[p]);
      write_reg(RegBands, ph_bands[p]);
      write_reg(RegChans, ph_chans[p]);
      send_idle_pct = ph_send[p];
      recv_stall_pct = ph_recv[p];
      // Long receiver hold-off while the sender keeps offering samples.
      if (p == 4) hold_req <= 1'b1;
      for (int n = 0; n < ph_items[p]; n++) begin
        it = random_item(($urandom_range(99) < 15) ? ModeLoad : ModeFilter);
        send_item(it);
      end
    end
    drain();

    $display("Covered %0d loads and %0d filtered samples, %0d band results checked,",
             sb.loads_seen, sb.samples_seen, sb.results_seen);
    $display("over orders 0 to 15, band counts 0 to 31 and channel counts 0 to 3.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
